// File: hdl/abst_pkg.sv
// Shared types and constants for the array binary search tree block.
// No dependencies; imported by abst_ctrl, abst_dp and array_bst_insert_search.
`timescale 1ns / 1ps
package abst_pkg;

  localparam int NODES_DEF = 64;
  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int OUT_IDX_W = 6;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_FOUND     = 3'd1;
  localparam status_t ST_NOT_FOUND = 3'd2;
  localparam status_t ST_PRESENT   = 3'd3;
  localparam status_t ST_INVALID   = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture opcode and key
    logic    root_go;     // read the root's child
    logic    step_go;     // read the next child
    logic    ins_wr;      // store key at current node
    logic    clr_wr;      // clear one entry during the sweep
    logic    fin;         // register a result
    status_t fin_status;
    logic    fin_use_idx; // report current node, else zero
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;
    logic key_eq_marker;
    logic node_empty;
    logic node_hit;
    logic next_over;
    logic clr_last;
  } dp_sts_t;

endpackage

// File: hdl/array_bst_insert_search.sv
// Top level of the implicit-array binary search tree (insert / search).
// Depends on abst_pkg, abst_ctrl and abst_dp.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. in_opcode selects insert (0) or search (1) of in_key_value.
//   Result channel: out_valid is high for exactly one cycle with out_status
//   and out_node_index; the receiver cannot stall it and must take it then.
//   Config channel: cfg_valid/cfg_ready write cfg_empty_marker, the value the
//   root stands for. cfg_ready is always high; write only while idle.
// Timing:
//   The root is decided against the marker first, then the walk visits
//   one tree level per cycle (one memory read per level, the next address is
//   chosen from the registered read data), then the result is registered.
//   A key equal to the marker ends at the root with no read; else the walk
//   visits D levels, at most floor(log2(NODES)) (6 for 64 nodes). One
//   transaction at a time; busy is low again in the cycle the result is on
//   the ports, so a new command may overlap it.
// Reset:
//   rst_n (synchronous) clears the marker to 0 and starts a clearing sweep of
//   all NODES entries that zeroes every valid bit; busy stays high meanwhile.
`timescale 1ns / 1ps
module array_bst_insert_search #(
  parameter int NODES = abst_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic signed [abst_pkg::KEY_W-1:0] in_key_value,
  output logic                              out_valid,
  output logic [abst_pkg::STATUS_W-1:0]     out_status,
  output logic [abst_pkg::OUT_IDX_W-1:0]    out_node_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic signed [abst_pkg::KEY_W-1:0] cfg_empty_marker
);
  import abst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // marker register accepts a write every cycle
  assign cfg_ready = 1'b1;

  abst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  abst_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_key_value     (in_key_value),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_empty_marker (cfg_empty_marker),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_node_index   (out_node_index)
  );

endmodule

// File: hdl/abst_dp.sv
// Datapath: marker register, node memory with valid bit, walk index, result registers.
// Depends on abst_pkg.
`timescale 1ns / 1ps
module abst_dp #(
  parameter int NODES = abst_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  abst_pkg::dp_cmd_t                 cmd,
  output abst_pkg::dp_sts_t                 sts,
  input  logic                              in_opcode,
  input  logic signed [abst_pkg::KEY_W-1:0] in_key_value,
  input  logic                              cfg_we,
  input  logic signed [abst_pkg::KEY_W-1:0] cfg_empty_marker,
  output logic                              out_valid,
  output logic [abst_pkg::STATUS_W-1:0]     out_status,
  output logic [abst_pkg::OUT_IDX_W-1:0]    out_node_index
);
  import abst_pkg::*;

  localparam int IDX_W  = $clog2(NODES);
  localparam int WALK_W = $clog2(2 * NODES + 1);

  // entry = {valid, key}
  logic [KEY_W:0]        mem [NODES];
  logic [KEY_W:0]        rdata_r;
  logic signed [KEY_W-1:0] marker_r;
  logic signed [KEY_W-1:0] key_r;
  logic                  op_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      clr_cnt_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [OUT_IDX_W-1:0]  out_idx_r;

  logic signed [KEY_W-1:0] node_key;
  logic                  lt_node;
  logic [WALK_W-1:0]     next_idx;
  logic [IDX_W-1:0]      root_child;
  logic [IDX_W-1:0]      rd_addr;
  logic                  rd_en;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_W:0]        wr_data;

  assign node_key   = $signed(rdata_r[KEY_W-1:0]);
  assign lt_node    = key_r < node_key;
  assign next_idx   = WALK_W'({idx_r, 1'b0}) + (lt_node ? WALK_W'(1) : WALK_W'(2));
  assign root_child = (key_r < marker_r) ? IDX_W'(1) : IDX_W'(2);

  assign rd_en   = cmd.root_go | cmd.step_go;
  assign rd_addr = cmd.root_go ? root_child : next_idx[IDX_W-1:0];

  assign wr_en   = cmd.ins_wr | cmd.clr_wr;
  assign wr_addr = cmd.clr_wr ? clr_cnt_r : idx_r;
  assign wr_data = cmd.clr_wr ? '0 : {1'b1, key_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key_value;
      op_r  <= in_opcode;
    end
    if (cmd.root_go) begin
      idx_r <= root_child;
    end else if (cmd.step_go) begin
      idx_r <= next_idx[IDX_W-1:0];
    end
    if (cmd.fin) begin
      out_status_r <= cmd.fin_status;
      out_idx_r    <= cmd.fin_use_idx ? OUT_IDX_W'(idx_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r    <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        marker_r <= cfg_empty_marker;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      out_valid_r <= cmd.fin;
    end
  end

  assign sts.is_search     = (op_r == OP_SEARCH);
  assign sts.key_eq_marker = (key_r == marker_r);
  assign sts.node_empty    = ~rdata_r[KEY_W];
  assign sts.node_hit      = rdata_r[KEY_W] & (node_key == key_r);
  assign sts.next_over     = (next_idx >= WALK_W'(NODES));
  assign sts.clr_last      = (clr_cnt_r == IDX_W'(NODES - 1));

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_idx_r;

endmodule

// File: hdl/abst_ctrl.sv
// Controller FSM: clear sweep, root decision, one tree level per cycle.
// Depends on abst_pkg.
`timescale 1ns / 1ps
module abst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  abst_pkg::dp_sts_t sts,
  output abst_pkg::dp_cmd_t cmd
);
  import abst_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ROOT  = 2'd2;
  localparam logic [1:0] S_LOOK  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sts.key_eq_marker) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = sts.is_search ? ST_FOUND : ST_INVALID;
          state_nxt      = S_IDLE;
        end else begin
          cmd.root_go = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        priority if (sts.node_empty) begin
          cmd.fin = 1'b1;
          if (sts.is_search) begin
            cmd.fin_status = ST_NOT_FOUND;
          end else begin
            cmd.ins_wr      = 1'b1;
            cmd.fin_status  = ST_INSERTED;
            cmd.fin_use_idx = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (sts.node_hit) begin
          cmd.fin         = 1'b1;
          cmd.fin_status  = sts.is_search ? ST_FOUND : ST_PRESENT;
          cmd.fin_use_idx = 1'b1;
          state_nxt       = S_IDLE;
        end else if (sts.next_over) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = sts.is_search ? ST_NOT_FOUND : ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.step_go = 1'b1;
        end
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for array_bst_insert_search: directed and random
// insert/search traffic checked against a tree walk predictor built into the bench.
// Depends on abst_pkg and the array_bst_insert_search RTL.
`timescale 1ns / 1ps
module testbench;
  import abst_pkg::*;

  localparam int TREE_NODES  = NODES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  // drain margin on top of the worst accept-to-strobe time
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    logic                     op;
    logic signed [KEY_W-1:0]  key;
    status_t                  status;
    logic [OUT_IDX_W-1:0]     index;
  } walk_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_opcode;
  logic signed [KEY_W-1:0]  in_key_value;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [OUT_IDX_W-1:0]     out_node_index;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic signed [KEY_W-1:0]  cfg_empty_marker;

  // predictor's copy of the tree and the marker register
  logic signed [KEY_W-1:0]  tree_key [TREE_NODES];
  bit                       tree_used [TREE_NODES];
  logic signed [KEY_W-1:0]  marker_model;

  walk_result_t             walk_results_q[$];
  logic signed [KEY_W-1:0]  seen_keys[$];
  walk_result_t             oldest_walk;
  int                       mismatch_count;
  int                       cycle_count;

  array_bst_insert_search #(.NODES(TREE_NODES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_key_value     (in_key_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_node_index   (out_node_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_empty_marker (cfg_empty_marker)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH t=%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Walk the predicted tree for one command. Inserts update the model as the
  // RTL would. Root is implicit: it stands for the marker, never stored.
  task automatic tree_walk(input logic op, input logic signed [KEY_W-1:0] key,
                           output walk_result_t res);
    int unsigned i;
    bit          search;
    search    = (op == OP_SEARCH);
    res.op    = op;
    res.key   = key;
    res.index = '0;
    if (key == marker_model) begin
      // marker: found at the root on search, rejected on insert
      res.status = search ? ST_FOUND : ST_INVALID;
    end else begin
      i = (key < marker_model) ? 1 : 2;
      // falling off the bottom of the table leaves this default
      res.status = search ? ST_NOT_FOUND : ST_FULL;
      while (i < TREE_NODES) begin
        if (!tree_used[i]) begin
          if (!search) begin
            tree_key[i]  = key;
            tree_used[i] = 1'b1;
            res.status   = ST_INSERTED;
            res.index    = i[OUT_IDX_W-1:0];
          end
          break;
        end
        if (tree_key[i] == key) begin
          res.status = search ? ST_FOUND : ST_PRESENT;
          res.index  = i[OUT_IDX_W-1:0];
          break;
        end
        i = (key < tree_key[i]) ? 2 * i + 1 : 2 * i + 2;
      end
    end
  endtask

  // Result checker: every strobe must match the oldest pending walk.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (walk_results_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status=%0d index=%0d",
                                  out_status, out_node_index));
      end else begin
        oldest_walk = walk_results_q.pop_front();
        if (out_status !== oldest_walk.status)
          report_mismatch($sformatf("status op=%0d key=%0d expected %0d got %0d",
                                    oldest_walk.op, oldest_walk.key,
                                    oldest_walk.status, out_status));
        if (out_node_index !== oldest_walk.index)
          report_mismatch($sformatf("node_index op=%0d key=%0d expected %0d got %0d",
                                    oldest_walk.op, oldest_walk.key,
                                    oldest_walk.index, out_node_index));
      end
    end
  end

  // One command transaction. Start stays high on return; whatever runs next
  // sets it at the following falling edge.
  task automatic send_command(input logic op, input logic signed [KEY_W-1:0] key);
    walk_result_t res;
    @(negedge clk);
    start        = 1'b1;
    in_opcode    = op;
    in_key_value = key;
    do @(posedge clk); while (busy !== 1'b0);
    tree_walk(op, key, res);
    walk_results_q.push_back(res);
    seen_keys.push_back(key);
    if (seen_keys.size() > 48)
      void'(seen_keys.pop_front());
  endtask

  // Sender gap with junk on the command fields.
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start        = 1'b0;
      in_opcode    = 1'($urandom);
      in_key_value = $urandom;
    end
  endtask

  // Block idle: no walk pending and busy low (also covers the reset sweep).
  task automatic wait_drained;
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (walk_results_q.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_marker(input logic signed [KEY_W-1:0] value);
    wait_drained();
    repeat ($urandom_range(0, 3)) @(posedge clk);
    @(negedge clk);
    cfg_valid        = 1'b1;
    cfg_empty_marker = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    marker_model = value;
    @(negedge clk);
    cfg_valid        = 1'b0;
    cfg_empty_marker = $urandom;
  endtask

  // Key mix: repeats of recent keys for hits, the marker, boundary values,
  // and either full-range or near-marker fresh keys.
  function automatic logic signed [KEY_W-1:0] pick_key(input bit narrow);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && seen_keys.size() > 0)
      return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    if (r < 45)
      return marker_model;
    if (r < 55) begin
      case ($urandom_range(0, 5))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sd0;
        3:       return -32'sd1;
        4:       return marker_model + 32'sd1;
        default: return marker_model - 32'sd1;
      endcase
    end
    if (narrow)
      return marker_model + $signed(KEY_W'($urandom_range(0, 400))) - 32'sd200;
    return $urandom;
  endfunction

  // Fresh tree, marker 0: marker handling on an empty table.
  task automatic test_after_reset;
    send_command(OP_SEARCH, 32'sd0);   // marker: found at root
    send_command(OP_SEARCH, 32'sd5);   // empty right child: not found
    send_command(OP_INSERT, 32'sd0);   // marker insert rejected
  endtask

  // Ascending keys march down the right spine until they drop off the table.
  task automatic test_chain_to_full;
    send_command(OP_INSERT, 32'sd100);
    send_command(OP_INSERT, 32'sd200);
    send_command(OP_INSERT, 32'sd300);
    send_command(OP_INSERT, 32'sd400);
    send_command(OP_INSERT, 32'sd500);
    send_command(OP_INSERT, 32'sd600); // past the last level: full
    send_command(OP_SEARCH, 32'sd700); // same path: not found
    send_command(OP_SEARCH, 32'sd300); // hit mid-chain
    wait_drained();
  endtask

  task automatic test_key_extremes;
    send_command(OP_INSERT, 32'sh7fff_ffff);
    send_command(OP_INSERT, 32'sh8000_0000);
    send_command(OP_INSERT, -32'sd1);
    send_command(OP_INSERT, 32'sh7fff_ffff); // duplicate
    send_command(OP_SEARCH, 32'sh8000_0000);
    send_command(OP_SEARCH, 32'sd12345);
  endtask

  // Marker at both ends of the range; stored nodes stay put across changes.
  task automatic test_marker_extremes;
    write_marker(32'sh8000_0000);
    send_command(OP_SEARCH, 32'sh8000_0000);
    send_command(OP_INSERT, 32'sh8000_0000);
    send_command(OP_SEARCH, 32'sd300);
    write_marker(32'sh7fff_ffff);
    send_command(OP_INSERT, 32'sh7fff_ffff);
    send_command(OP_SEARCH, -32'sd1);
  endtask

  task automatic run_random_phase(input int count, input logic signed [KEY_W-1:0] marker,
                                  input bit narrow, input bit no_gaps);
    int n;
    write_marker(marker);
    for (n = 0; n < count; n++) begin
      if (!no_gaps && $urandom_range(0, 99) < 20)
        hold_off($urandom_range(1, 10));
      if ($urandom_range(0, 59) == 0)
        wait_drained();
      send_command(1'($urandom_range(0, 1)), pick_key(narrow));
    end
  endtask

  task automatic test_random_traffic;
    run_random_phase(150, $urandom, 1'b0, 1'b0);
    run_random_phase(150, 32'sh8000_0000, 1'b1, 1'b1);  // back-to-back stretch
    run_random_phase(150, 32'sh7fff_ffff, 1'b0, 1'b0);
    run_random_phase(150, $signed(KEY_W'($urandom_range(0, 200))) - 32'sd100,
                     1'b1, 1'b0);
  endtask

  initial begin
    int i;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_opcode        = 1'b0;
    in_key_value     = '0;
    cfg_valid        = 1'b0;
    cfg_empty_marker = '0;
    mismatch_count   = 0;
    cycle_count      = 0;
    marker_model     = '0;
    for (i = 0; i < TREE_NODES; i++) begin
      tree_key[i]  = '0;
      tree_used[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_chain_to_full();
    test_key_extremes();
    test_marker_extremes();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && walk_results_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/abst_pkg.sv
hdl/abst_dp.sv
hdl/abst_ctrl.sv
hdl/array_bst_insert_search.sv
tb/sv/testbench.sv
